@@ design/blus_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded list store package
// Shared sizes, operation codes, item types and the control/status structs
// that join the list controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package blus_pkg;

  // Storage sizes.
  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;

  // Operation codes carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_DEL_FIRST = 3'd2,
    OP_DEL_ALL   = 3'd3,
    OP_DEL_ODD   = 3'd4
  } op_e;

  // One input item.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } item_in_t;

  // One result item.
  typedef struct packed {
    logic                     ok;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
    logic signed [DATA_W-1:0] min_value;
  } item_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                     load;       // latch value, op and start a walk
    logic                     down;       // walk downwards (head insert shift)
    logic                     step;       // issue the next read of the walk
    logic                     append;     // write value at the tail
    logic                     head_write; // write value at the head
    logic                     commit;     // take the compacted count and minimum
    logic [OP_W-1:0]          op;
    logic [DATA_W-1:0]        value;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                     is_empty;
    logic                     is_full;
    logic                     walk_done;  // all reads issued and written back
    logic                     found;      // a remove-first match was dropped
    logic [CNT_W-1:0]         count;
    logic [DATA_W-1:0]        min_value;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/bounded_unordered_list_store.sv @@
// ----------------------------------------------------------------------------
// Bounded list store
// A compact array of up to 32 signed words with append, head insert and
// three kinds of removal; every item returns one status result.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An append writes the tail directly; an
// insert at the head and a removal first walk over every stored entry,
// because the element memory has one read port and the shift or
// compaction walk visits one entry per cycle. A failed insert on a full
// list, a removal on an empty list or an unused op code skips the walk and
// goes straight to its result. The next item can be accepted in the cycle
// after the result is loaded. The result sits in an output register, so a
// new item may be accepted while the previous result is still waiting; its
// own result then waits until that register is free.
// Inserts on a full list and removals on an empty list fail without change;
// the reported minimum is zero when the list is empty.
`default_nettype none

module bounded_unordered_list_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire blus_pkg::item_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output blus_pkg::item_out_t     out_data_o
);

  blus_pkg::dp_cmd_t    dp_cmd;
  blus_pkg::dp_status_t dp_status;

  // Sequencing and handshakes.
  blus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  // Element storage and walk.
  blus_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .status_o (dp_status)
  );

endmodule

`default_nettype wire

@@ design/blus_datapath.sv @@
// ----------------------------------------------------------------------------
// Bounded list store datapath
// Element memory with one write and one registered read port, the walk
// counters, the compaction write pointer, the element count and the
// running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module blus_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire blus_pkg::dp_cmd_t    cmd_i,
  output blus_pkg::dp_status_t      status_o
);

  // Element memory.
  logic [blus_pkg::DATA_W-1:0] mem_q [blus_pkg::CAPACITY];

  // Control registers.
  logic [blus_pkg::CNT_W-1:0]  count_q;
  logic [blus_pkg::CNT_W-1:0]  rd_left_q;
  logic [blus_pkg::CNT_W-1:0]  rd_ptr_q;
  logic [blus_pkg::CNT_W-1:0]  kept_q;
  logic                        rd_vld_q;
  logic                        found_q;

  // Payload registers.
  logic [blus_pkg::DATA_W-1:0] rd_data_q;
  logic [blus_pkg::AW-1:0]     rd_addr_q;
  logic [blus_pkg::DATA_W-1:0] value_q;
  logic [blus_pkg::OP_W-1:0]   op_q;
  logic [blus_pkg::DATA_W-1:0] min_q;
  logic [blus_pkg::DATA_W-1:0] scan_min_q;

  // Write port and decisions.
  logic                        rd_issue;
  logic                        mem_we;
  logic [blus_pkg::AW-1:0]     mem_waddr;
  logic [blus_pkg::DATA_W-1:0] mem_wdata;
  logic                        match;
  logic                        drop;
  logic                        keep_wr;
  logic                        is_first_op;
  logic                        value_is_min;

  // A read is issued while the walk still has entries to visit.
  assign rd_issue = cmd_i.step && (rd_left_q != '0);

  // Drop decision for the entry coming out of the memory.
  assign match       = (rd_data_q == value_q);
  assign is_first_op = (op_q == blus_pkg::OP_DEL_FIRST);

  always_comb begin
    unique case (op_q)
      blus_pkg::OP_DEL_FIRST: drop = match && !found_q;
      blus_pkg::OP_DEL_ALL:   drop = match;
      blus_pkg::OP_DEL_ODD:   drop = rd_data_q[0];
      default:                drop = 1'b0;
    endcase
  end

  assign keep_wr = rd_vld_q && !cmd_i.down && !drop;

  // The new value becomes the minimum when the list is empty or it is smaller.
  assign value_is_min = (count_q == '0) || ($signed(value_q) < $signed(min_q));

  // Single write port: tail append, head write, shifted or kept entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data_q;
    priority if (cmd_i.append) begin
      mem_we    = 1'b1;
      mem_waddr = count_q[blus_pkg::AW-1:0];
      mem_wdata = value_q;
    end else if (cmd_i.head_write) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = value_q;
    end else if (rd_vld_q && cmd_i.down) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_q + blus_pkg::AW'(1);
    end else if (keep_wr) begin
      mem_we    = 1'b1;
      mem_waddr = kept_q[blus_pkg::AW-1:0];
    end else begin
      mem_we    = 1'b0;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_issue) begin
      rd_data_q <= mem_q[rd_ptr_q[blus_pkg::AW-1:0]];
      rd_addr_q <= rd_ptr_q[blus_pkg::AW-1:0];
    end
  end

  // Payload registers: latched value and op, running minima.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= cmd_i.value;
      op_q    <= cmd_i.op;
    end
    if (keep_wr && ((kept_q == '0) || ($signed(rd_data_q) < $signed(scan_min_q)))) begin
      scan_min_q <= rd_data_q;
    end
    if ((cmd_i.append || cmd_i.head_write) && value_is_min) begin
      min_q <= value_q;
    end else if (cmd_i.commit) begin
      min_q <= scan_min_q;
    end
  end

  // Control registers: count, walk counters, compaction pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_left_q <= '0;
      rd_ptr_q  <= '0;
      kept_q    <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
      if (cmd_i.load) begin
        rd_left_q <= count_q;
        rd_ptr_q  <= cmd_i.down ? (count_q - blus_pkg::CNT_W'(1)) : '0;
        kept_q    <= '0;
        found_q   <= 1'b0;
      end else if (rd_issue) begin
        rd_left_q <= rd_left_q - blus_pkg::CNT_W'(1);
        rd_ptr_q  <= cmd_i.down ? (rd_ptr_q - blus_pkg::CNT_W'(1))
                                : (rd_ptr_q + blus_pkg::CNT_W'(1));
      end
      if (keep_wr) begin
        kept_q <= kept_q + blus_pkg::CNT_W'(1);
      end
      if (rd_vld_q && !cmd_i.down && drop && is_first_op) begin
        found_q <= 1'b1;
      end
      if (cmd_i.append || cmd_i.head_write) begin
        count_q <= count_q + blus_pkg::CNT_W'(1);
      end else if (cmd_i.commit) begin
        count_q <= kept_q;
      end
    end
  end

  // Status towards the controller.
  always_comb begin
    status_o.count     = count_q;
    status_o.is_empty  = (count_q == '0);
    status_o.is_full   = (count_q == blus_pkg::CNT_W'(blus_pkg::CAPACITY));
    status_o.walk_done = (rd_left_q == '0) && !rd_vld_q;
    status_o.found     = found_q;
    status_o.min_value = (count_q == '0) ? '0 : min_q;
  end

endmodule

`default_nettype wire

@@ design/blus_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded list store controller
// Accepts one item at a time, sequences the datapath through the append,
// head insert or compaction walk, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blus_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire blus_pkg::item_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output blus_pkg::item_out_t       out_data_o,
  output blus_pkg::dp_cmd_t         cmd_o,
  input  wire blus_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SHIFT,
    ST_HEAD,
    ST_COMPACT,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [blus_pkg::OP_W-1:0] op_q;
  logic                      ok_q;
  logic                      out_valid_q;
  blus_pkg::item_out_t       out_data_q;

  logic                      accept;
  logic                      out_free;
  logic                      walk_end;
  logic                      is_del;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign walk_end = status_i.walk_done;
  assign is_del   = (in_data_i.op == blus_pkg::OP_DEL_FIRST) ||
                    (in_data_i.op == blus_pkg::OP_DEL_ALL) ||
                    (in_data_i.op == blus_pkg::OP_DEL_ODD);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Commands to the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.op         = in_data_i.op;
    cmd_o.value      = in_data_i.value;
    cmd_o.down       = (state_q == ST_IDLE) ? (in_data_i.op == blus_pkg::OP_PREPEND)
                                            : (state_q == ST_SHIFT);
    cmd_o.step       = (state_q == ST_SHIFT) || (state_q == ST_COMPACT);
    cmd_o.append     = (state_q == ST_APPEND);
    cmd_o.head_write = (state_q == ST_HEAD);
    cmd_o.commit     = (state_q == ST_COMPACT) && walk_end;
  end

  // State, success flag and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // The done state reloads the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q <= in_data_i.op;
            ok_q <= 1'b0;
            priority if ((in_data_i.op == blus_pkg::OP_APPEND) && !status_i.is_full) begin
              state_q <= ST_APPEND;
            end else if ((in_data_i.op == blus_pkg::OP_PREPEND) && !status_i.is_full) begin
              state_q <= ST_SHIFT;
            end else if (is_del && !status_i.is_empty) begin
              state_q <= ST_COMPACT;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_APPEND: begin
          ok_q    <= 1'b1;
          state_q <= ST_DONE;
        end
        ST_SHIFT: begin
          if (walk_end) begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          ok_q    <= 1'b1;
          state_q <= ST_DONE;
        end
        ST_COMPACT: begin
          if (walk_end) begin
            ok_q    <= (op_q == blus_pkg::OP_DEL_FIRST) ? status_i.found : 1'b1;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_data_q.ok        <= ok_q;
            out_data_q.count     <= status_i.count;
            out_data_q.is_empty  <= status_i.is_empty;
            out_data_q.is_full   <= status_i.is_full;
            out_data_q.min_value <= status_i.min_value;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Bounded list store testbench
// Drives a directed table and then a long run of random items through the
// list store. Random items are grouped into filling, draining and mixed
// phases. Each result is checked against a behavioural copy of the list
// or a typed row's status. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Op codes that the block must ignore.
  localparam logic [blus_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [blus_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [blus_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 2 * (blus_pkg::CAPACITY + 5) + 10;

  // Status after a failed operation on an empty list.
  localparam blus_pkg::item_out_t EMPTY_FAIL = {1'b0, 6'd0, 1'b1, 1'b0, 32'sd0};
  localparam blus_pkg::item_out_t UNTYPED    = '0;

  typedef struct packed {
    logic [blus_pkg::OP_W-1:0]          op;
    logic signed [blus_pkg::DATA_W-1:0] value;
    logic                               typed;
    blus_pkg::item_out_t                want;
  } directed_row_t;

  localparam int DIRECTED_LEN = 22;

  // Directed items; a typed row carries the status that is read off directly.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{blus_pkg::OP_DEL_FIRST, 32'sd5,        1'b1, EMPTY_FAIL},
    '{blus_pkg::OP_DEL_ALL,   32'sd5,        1'b1, EMPTY_FAIL},
    '{blus_pkg::OP_DEL_ODD,   32'sd0,        1'b1, EMPTY_FAIL},
    '{OP_SPARE_FIRST,         32'sd0,        1'b1, EMPTY_FAIL},
    '{blus_pkg::OP_APPEND,    32'h7FFF_FFFF, 1'b1, {1'b1, 6'd1, 1'b0, 1'b0, 32'h7FFF_FFFF}},
    '{blus_pkg::OP_PREPEND,   32'h8000_0000, 1'b1, {1'b1, 6'd2, 1'b0, 1'b0, 32'h8000_0000}},
    '{blus_pkg::OP_APPEND,    32'sd0,        1'b0, UNTYPED},
    '{blus_pkg::OP_APPEND,    32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{blus_pkg::OP_PREPEND,   32'sd3,        1'b0, UNTYPED},
    '{blus_pkg::OP_APPEND,    32'sd3,        1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_FIRST, 32'sd42,       1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_ALL,   32'sd42,       1'b0, UNTYPED},
    '{OP_SPARE_LAST,          32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_ALL,   32'sd3,        1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_FIRST, 32'h8000_0000, 1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_ODD,   32'h1234_5678, 1'b0, UNTYPED},
    '{blus_pkg::OP_APPEND,    32'hFFFF_FFFA, 1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_ODD,   32'sd0,        1'b0, UNTYPED},
    '{OP_SPARE_MID,           32'sd1,        1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_FIRST, 32'sd0,        1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_FIRST, 32'hFFFF_FFFA, 1'b0, UNTYPED},
    '{blus_pkg::OP_DEL_FIRST, 32'hFFFF_FFFA, 1'b1, EMPTY_FAIL}
  };

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  blus_pkg::item_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  blus_pkg::item_out_t out_data;

  // Behavioural copy of the list and the statuses still to arrive.
  logic signed [blus_pkg::DATA_W-1:0] list_model[$];
  blus_pkg::item_out_t                expected_status_q[$];

  int mismatch_count = 0;
  int result_index   = 0;
  int burst_left     = 0;
  int gap_cycles     = 0;

  bounded_unordered_list_store i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one item to the list copy and returns the status it should give.
  function automatic blus_pkg::item_out_t apply_to_list(
      input logic [blus_pkg::OP_W-1:0] op,
      input logic signed [blus_pkg::DATA_W-1:0] value);
    blus_pkg::item_out_t                status;
    logic signed [blus_pkg::DATA_W-1:0] kept[$];
    logic signed [blus_pkg::DATA_W-1:0] low_word;
    logic                               drop;
    int                                 hit;
    status = '0;
    hit    = -1;
    case (op)
      blus_pkg::OP_APPEND: begin
        if (list_model.size() < blus_pkg::CAPACITY) begin
          list_model.push_back(value);
          status.ok = 1'b1;
        end
      end
      blus_pkg::OP_PREPEND: begin
        if (list_model.size() < blus_pkg::CAPACITY) begin
          list_model.push_front(value);
          status.ok = 1'b1;
        end
      end
      blus_pkg::OP_DEL_FIRST: begin
        foreach (list_model[i]) if (hit < 0 && list_model[i] == value) hit = i;
        if (hit >= 0) begin
          list_model.delete(hit);
          status.ok = 1'b1;
        end
      end
      blus_pkg::OP_DEL_ALL, blus_pkg::OP_DEL_ODD: begin
        // Compaction keeps the survivors in their original order.
        if (list_model.size() > 0) begin
          foreach (list_model[i]) begin
            drop = (op == blus_pkg::OP_DEL_ALL) ? (list_model[i] == value)
                                                : list_model[i][0];
            if (!drop) kept.push_back(list_model[i]);
          end
          list_model = kept;
          status.ok  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    status.count    = blus_pkg::CNT_W'(list_model.size());
    status.is_empty = (list_model.size() == 0);
    status.is_full  = (list_model.size() == blus_pkg::CAPACITY);
    if (list_model.size() > 0) begin
      low_word = list_model[0];
      foreach (list_model[i]) if (list_model[i] < low_word) low_word = list_model[i];
      status.min_value = low_word;
    end
    return status;
  endfunction

  // Offers one item, in bursts with random gaps, and records its status.
  task automatic send_item(input blus_pkg::item_in_t item, input logic typed,
                           input blus_pkg::item_out_t want);
    blus_pkg::item_out_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_cycles > 0) begin
        in_valid <= 1'b0;
        repeat (gap_cycles) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_to_list(item.op, item.value);
    expected_status_q.push_back(typed ? want : predicted);
  endtask

  // Holds the input back until every outstanding status has come.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("Mismatch on result %0d, %s: expected %0d, got %0d",
               result_index, field, want, got);
  endtask

  // Stimulus: directed table, then phased random items.
  initial begin
    blus_pkg::item_in_t                 item;
    logic [blus_pkg::OP_W-1:0]          next_op;
    logic signed [blus_pkg::DATA_W-1:0] next_value;
    mix_e                               phase;
    int                                 phase_left;
    int                                 roll;
    int                                 pick;
    phase      = MIX_FILL;
    phase_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_LEN; r++) begin
      item.op    = DIRECTED_ROWS[r].op;
      item.value = DIRECTED_ROWS[r].value;
      send_item(item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = mix_e'($urandom_range(0, 2));
        phase_left = $urandom_range(15, 70);
      end
      phase_left--;

      // Operation, weighted by the current phase.
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        next_op = blus_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end else begin
        case (phase)
          MIX_FILL:  next_op = (roll < 45) ? blus_pkg::OP_APPEND :
                               (roll < 88) ? blus_pkg::OP_PREPEND :
                               (roll < 95) ? blus_pkg::OP_DEL_FIRST :
                               (roll < 98) ? blus_pkg::OP_DEL_ALL :
                               blus_pkg::OP_DEL_ODD;
          MIX_DRAIN: next_op = (roll < 12) ? blus_pkg::OP_APPEND :
                               (roll < 20) ? blus_pkg::OP_PREPEND :
                               (roll < 70) ? blus_pkg::OP_DEL_FIRST :
                               (roll < 90) ? blus_pkg::OP_DEL_ALL :
                               blus_pkg::OP_DEL_ODD;
          default:   next_op = (roll < 30) ? blus_pkg::OP_APPEND :
                               (roll < 55) ? blus_pkg::OP_PREPEND :
                               (roll < 80) ? blus_pkg::OP_DEL_FIRST :
                               (roll < 93) ? blus_pkg::OP_DEL_ALL :
                               blus_pkg::OP_DEL_ODD;
        endcase
      end

      // Value: mostly stored words for removals, small values for duplicates.
      pick = $urandom_range(0, 9);
      if ((next_op == blus_pkg::OP_DEL_FIRST || next_op == blus_pkg::OP_DEL_ALL) &&
          list_model.size() > 0 && pick < 7) begin
        next_value = list_model[$urandom_range(0, list_model.size() - 1)];
      end else if (pick < 4) begin
        next_value = int'($urandom_range(0, 8)) - 4;
      end else if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       next_value = 32'h7FFF_FFFF;
          1:       next_value = 32'h8000_0000;
          2:       next_value = 32'hFFFF_FFFF;
          default: next_value = 32'sd0;
        endcase
      end else begin
        next_value = $urandom;
      end

      item.op    = next_op;
      item.value = next_value;
      send_item(item, 1'b0, UNTYPED);
      if (n % 250 == 125) hold_until_drained();
    end

    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: checks each accepted result and stalls on changing patterns.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    blus_pkg::item_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result %0d arrived with nothing expected", result_index);
      end else begin
        want = expected_status_q.pop_front();
        if (out_data.ok !== want.ok) note_mismatch("ok", want.ok, out_data.ok);
        if (out_data.count !== want.count)
          note_mismatch("count", want.count, out_data.count);
        if (out_data.is_empty !== want.is_empty)
          note_mismatch("is_empty", want.is_empty, out_data.is_empty);
        if (out_data.is_full !== want.is_full)
          note_mismatch("is_full", want.is_full, out_data.is_full);
        if (out_data.min_value !== want.min_value)
          note_mismatch("min_value", want.min_value, out_data.min_value);
      end
      result_index++;
    end

    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Cycle counter that ends a run which has hung.
  initial begin
    for (int cycle = 0; cycle < CYCLE_LIMIT; cycle++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

endmodule
